@@ rtl/ntc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants for the thermistor sample converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int SampleW = 16;
    localparam int TempW   = 16;
    localparam int AccW    = 66;
    localparam int StartSamples = 3;

    localparam logic [1:0] CH_LENS    = 2'd0;
    localparam logic [1:0] CH_SHUTTER = 2'd1;
    localparam logic [1:0] CH_FPA     = 2'd2;
    localparam logic [1:0] CH_NONE    = 2'd3;

    localparam logic [0:0] REG_TEMP_LOW  = 1'd0;
    localparam logic [0:0] REG_TEMP_HIGH = 1'd1;

    localparam logic [63:0] CubicC0  = 64'd127361304901973000;
    localparam logic [63:0] CubicC1  = 64'd18218076216914;
    localparam logic [63:0] CubicC2  = 64'd1218402729;
    localparam logic [63:0] CubicC3  = 64'd40235;
    localparam logic [63:0] CubicDiv = 64'd10000000000000;
    localparam logic [63:0] LinC0    = 64'd3712900;
    localparam logic [63:0] LinC1    = 64'd201;
    localparam logic [63:0] LinDiv   = 64'd100;

    // request to the arithmetic unit
    typedef struct packed {
        logic               start;
        logic               linear;
        logic [SampleW-1:0] x;
    } ntc_req_t;

    // answer from the arithmetic unit
    typedef struct packed {
        logic                    done;
        logic signed [TempW-1:0] temp;
    } ntc_rsp_t;

endpackage
`default_nettype wire

@@ rtl/ntc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_if
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface ntc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [15:0] sample;
    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

interface ntc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel_echo;
    logic [15:0] temperature;
    logic        temp_valid;
    logic        start_captured;
    logic [15:0] start_sample;
    modport source (output valid, channel_echo, temperature, temp_valid,
                    start_captured, start_sample, input ready);
    modport sink   (input valid, channel_echo, temperature, temp_valid,
                    start_captured, start_sample, output ready);
endinterface

interface ntc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/ntc_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_mac
// Bit-serial polynomial evaluator and restoring divider with saturation.
// ----------------------------------------------------------------------------
module ntc_mac
    import ntc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ntc_req_t req,
    output ntc_rsp_t      rsp
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SQ   = 10'b0000000010,
        ST_CUBE = 10'b0000000100,
        ST_NEG3 = 10'b0000001000,
        ST_NEG1 = 10'b0000010000,
        ST_POS  = 10'b0000100000,
        ST_LIN  = 10'b0001000000,
        ST_SUM  = 10'b0010000000,
        ST_DIV  = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } mac_state_t;

    mac_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        lin_reg, lin_next;
    logic [15:0] x_reg, x_next;
    logic [31:0] mul_b_reg, mul_b_next;
    logic [63:0] mul_a_reg, mul_a_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] x2_reg, x2_next;
    logic [63:0] nsum_reg, nsum_next;
    logic [AccW-1:0] num_reg, num_next;
    logic [AccW-1:0] rem_reg, rem_next;
    logic [AccW-1:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;
    logic signed [TempW-1:0] temp_reg, temp_next;

    logic [63:0] dv, step_sum;
    logic [5:0]  last_cnt;
    logic [AccW-1:0] rem_sh;

    assign dv = lin_reg ? LinDiv : CubicDiv;
    assign rsp.done = (state_reg == ST_DONE);
    assign rsp.temp = temp_reg;

    // shift-add step, x^2 coefficient term runs over 32 multiplier bits
    assign step_sum = mul_b_reg[0] ? (prod_reg + mul_a_reg) : prod_reg;
    assign last_cnt = (state_reg == ST_POS) ? 6'd31 : 6'd15;

    assign rem_sh = {rem_reg[AccW-2:0], num_reg[AccW-1]};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lin_next   = lin_reg;
        x_next     = x_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        prod_next  = prod_reg;
        x2_next    = x2_reg;
        nsum_next  = nsum_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        temp_next  = temp_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (req.start)
                begin
                    lin_next   = req.linear;
                    x_next     = req.x;
                    mul_a_next = req.linear ? LinC1 : {48'd0, req.x};
                    mul_b_next = {16'd0, req.x};
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = req.linear ? ST_LIN : ST_SQ;
                end
            end
            ST_SQ, ST_CUBE, ST_NEG3, ST_NEG1, ST_POS, ST_LIN:
            begin
                // one multiplier bit per cycle
                prod_next  = step_sum;
                mul_a_next = {mul_a_reg[62:0], 1'b0};
                mul_b_next = {1'b0, mul_b_reg[31:1]};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == last_cnt)
                begin
                    cnt_next = '0;
                    unique case (state_reg)
                        ST_SQ:
                        begin
                            // x^2 done, multiply it by x next
                            x2_next    = step_sum[31:0];
                            mul_a_next = {32'd0, step_sum[31:0]};
                            mul_b_next = {16'd0, x_reg};
                            prod_next  = '0;
                            state_next = ST_CUBE;
                        end
                        ST_CUBE:
                        begin
                            // x^3 done, start the negative half with the cubic term
                            mul_a_next = {16'd0, step_sum[47:0]};
                            mul_b_next = CubicC3[31:0];
                            prod_next  = '0;
                            state_next = ST_NEG3;
                        end
                        ST_NEG3:
                        begin
                            // add the linear term onto the same sum
                            mul_a_next = CubicC1;
                            mul_b_next = {16'd0, x_reg};
                            state_next = ST_NEG1;
                        end
                        ST_NEG1:
                        begin
                            // negative half kept, positive half starts at the offset
                            nsum_next  = step_sum;
                            mul_a_next = CubicC2;
                            mul_b_next = x2_reg;
                            prod_next  = CubicC0;
                            state_next = ST_POS;
                        end
                        ST_POS:
                            state_next = ST_SUM;
                        ST_LIN:
                        begin
                            nsum_next  = step_sum;
                            prod_next  = LinC0;
                            state_next = ST_SUM;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUM:
            begin
                // sign and magnitude of the numerator, bottom two bits zero
                if (prod_reg >= nsum_reg)
                begin
                    num_next = {prod_reg - nsum_reg, 2'b00};
                    neg_next = 1'b0;
                end
                else
                begin
                    num_next = {nsum_reg - prod_reg, 2'b00};
                    neg_next = 1'b1;
                end
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle, 64 steps
                num_next = {num_reg[AccW-2:0], 1'b0};
                if (rem_sh >= {2'b00, dv})
                begin
                    rem_next = rem_sh - {2'b00, dv};
                    quo_next = {quo_reg[AccW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[AccW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // saturate on the final division step
        if (state_reg == ST_DIV && cnt_reg == 6'd63)
        begin
            if (!neg_reg)
                temp_next = (quo_next > 66'd32767) ? 16'sd32767 : quo_next[15:0];
            else if (quo_next > 66'd32768)
                temp_next = -16'sd32768;
            else
                temp_next = 16'(-quo_next[16:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg   <= lin_next;
        x_reg     <= x_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= prod_next;
        x2_reg    <= x2_next;
        nsum_reg  <= nsum_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        temp_reg  <= temp_next;
    end

endmodule
`default_nettype wire

@@ rtl/ntc_sample_to_temperature.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_sample_to_temperature
// Converts thermistor samples to hundredths of a degree with window check.
// ----------------------------------------------------------------------------
// One item at a time. A lens or shutter item passes through the arithmetic
// unit in order: the bit-serial shift-add products (x^2, x^3 and the three
// coefficient terms, 16 multiplier bits each, 32 for the x^2 term), a step
// to compare and subtract the two numerator halves, the one-bit-per-cycle
// divider by 10^13 and a step to hand the result over. A focal-plane item
// has a single 16-bit product, then the compare, the divide and the hand-over;
// a channel-none item skips the arithmetic and its result shows in the next
// cycle. The result waits in an output register until taken, and the input
// opens again in the cycle after that.
module ntc_sample_to_temperature
    import ntc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ntc_in_if.sink    in_ch,
    ntc_out_if.source out_ch,
    ntc_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_OUT  = 3'b100
    } top_state_t;

    top_state_t state_reg;
    logic signed [15:0] low_reg, high_reg;
    logic [1:0]  chan_reg;
    logic [1:0]  scount_reg;
    logic        sdone_reg;
    logic [15:0] svalue_reg;
    logic        capt_reg;
    logic signed [15:0] temp_reg;
    logic        tvalid_reg;
    ntc_req_t    req;
    ntc_rsp_t    rsp;
    logic        acc;
    logic [1:0]  scount_inc;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign acc = in_ch.valid && in_ch.ready;
    assign scount_inc = scount_reg + 2'd1;

    assign req.start  = acc && (in_ch.channel != CH_NONE);
    assign req.linear = (in_ch.channel == CH_FPA);
    assign req.x      = in_ch.sample;

    ntc_mac u_mac (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign out_ch.valid          = (state_reg == ST_OUT);
    assign out_ch.channel_echo   = chan_reg;
    assign out_ch.temperature    = temp_reg;
    assign out_ch.temp_valid     = tvalid_reg;
    assign out_ch.start_captured = capt_reg;
    assign out_ch.start_sample   = svalue_reg;

    // control, window registers and start reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            low_reg    <= -16'sd2000;
            high_reg   <= 16'sd7000;
            scount_reg <= '0;
            sdone_reg  <= 1'b0;
            svalue_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TEMP_LOW:  low_reg  <= cfg.data;
                    REG_TEMP_HIGH: high_reg <= cfg.data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        state_reg <= (in_ch.channel == CH_NONE) ? ST_OUT : ST_BUSY;
                        if (in_ch.channel == CH_SHUTTER && !sdone_reg)
                        begin
                            scount_reg <= scount_inc;
                            if (scount_inc == 2'(StartSamples))
                            begin
                                sdone_reg  <= 1'b1;
                                svalue_reg <= in_ch.sample;
                            end
                        end
                    end
                end
                ST_BUSY:
                    if (rsp.done)
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (out_ch.ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            chan_reg   <= in_ch.channel;
            capt_reg   <= (in_ch.channel == CH_SHUTTER) && !sdone_reg
                          && (scount_inc == 2'(StartSamples));
            temp_reg   <= '0;
            tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_BUSY && rsp.done)
        begin
            temp_reg   <= rsp.temp;
            tvalid_reg <= (rsp.temp >= low_reg) && (rsp.temp <= high_reg);
        end
    end

endmodule
`default_nettype wire

@@ rtl/ntc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker
    import ntc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  channel_echo,
    input wire logic        temp_valid,
    input wire logic        start_captured,
    input wire logic [15:0] temperature
);

    // one item at a time: no input taken while a result waits
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    // the input is closed right after an item is taken
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input open right after an item was taken");

    // channel none never valid and zero
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && channel_echo == CH_NONE) |-> (!temp_valid && temperature == 16'd0))
        else $error("channel none result not empty");

    // capture only on shutter items
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_captured) |-> (channel_echo == CH_SHUTTER))
        else $error("capture on non-shutter item");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(temperature)))
        else $error("stalled result changed");

endmodule

bind ntc_sample_to_temperature ntc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .channel_echo(out_ch.channel_echo), .temp_valid(out_ch.temp_valid),
    .start_captured(out_ch.start_captured), .temperature(out_ch.temperature)
);
`default_nettype wire
